### rtl/core/ceps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceps_pkg
// Shared constants, stage types and the month table for the date to epoch
// seconds pipeline.
// ----------------------------------------------------------------------------
package ceps_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinW    = 6;
  localparam int SecW    = 6;
  localparam int OutW    = 38;

  // day count, kept modulo 2^DaysW; true values fit as two's complement
  localparam int DaysW   = 25;
  localparam int MstartW = 9;
  localparam int TodW    = 17;

  localparam int EpochYear   = 1970;
  localparam int DaysPerYear = 365;
  localparam int SecsPerMin  = 60;
  localparam int MinsPerHour = 60;
  localparam int HoursPerDay = 24;
  localparam int SecsPerHour = SecsPerMin * MinsPerHour;
  localparam int SecsPerDay  = SecsPerHour * HoursPerDay;

  // leap-year counts are taken on year + LeapShift to keep operands positive
  localparam int LeapShift = 399;
  localparam int LeapBase  = (EpochYear + LeapShift) / 4 - (EpochYear + LeapShift) / 100
                             + (EpochYear + LeapShift) / 400;

  // x / 25 as (x * Recip25) >> RecipSh, exact for x below 2^RecipSh / 7
  localparam int RecipSh = 15;
  localparam int Recip25 = (1 << RecipSh) / 25 + 1;

  localparam int NqW = 13;  // (year + 399) >> 2
  localparam int YqW = 12;  // year >> 2
  localparam int PnW = NqW + 11;
  localparam int PyW = YqW + 11;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  typedef struct packed {
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } tod_fields_t;

  // front end result, handed to the day adder
  typedef struct packed {
    logic [DaysW-1:0]   year_days;
    logic [DaysW-1:0]   leaps;
    logic [MstartW-1:0] mstart;
    logic               leap_add;
    tod_fields_t        tf;
  } front_t;

  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [TodW-1:0]  tod;
  } days_t;

  // days before the first of the month in a common year; month zero acts as
  // January and anything past December as December
  function automatic logic [MstartW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [MstartW-1:0] r;
    case (m)
      4'd0, 4'd1: r = 9'd0;
      4'd2:       r = 9'd31;
      4'd3:       r = 9'd59;
      4'd4:       r = 9'd90;
      4'd5:       r = 9'd120;
      4'd6:       r = 9'd151;
      4'd7:       r = 9'd181;
      4'd8:       r = 9'd212;
      4'd9:       r = 9'd243;
      4'd10:      r = 9'd273;
      4'd11:      r = 9'd304;
      default:    r = 9'd334;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/ceps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceps_front
// Stages 1 and 2: reciprocal divides by 100 and 400, leap-year test,
// year day count and month table lookup.
// ----------------------------------------------------------------------------
module ceps_front (
  input  logic                         clk,
  input  ceps_pkg::stage_en_t          en,
  input  logic [ceps_pkg::YearW-1:0]   year,
  input  logic [ceps_pkg::MonthW-1:0]  month,
  input  ceps_pkg::tod_fields_t        tf,
  output ceps_pkg::front_t             front
);

  // stage 1
  logic [ceps_pkg::YearW-1:0]   yr_r;
  logic [ceps_pkg::NqW-1:0]     nq_r;
  logic [ceps_pkg::PnW-1:0]     pn_r;
  logic [ceps_pkg::PyW-1:0]     py_r;
  logic [ceps_pkg::MstartW-1:0] ms_r;
  logic                         late_r;
  ceps_pkg::tod_fields_t        tf1_r;

  logic [ceps_pkg::YearW:0]     n_full;
  logic [ceps_pkg::NqW-1:0]     nq_nxt;
  logic [ceps_pkg::YqW-1:0]     yq_nxt;

  assign n_full = (ceps_pkg::YearW+1)'(year) + (ceps_pkg::YearW+1)'(ceps_pkg::LeapShift);
  assign nq_nxt = n_full[ceps_pkg::YearW:2];
  assign yq_nxt = year[ceps_pkg::YearW-1:2];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      yr_r   <= year;
      nq_r   <= nq_nxt;
      pn_r   <= ceps_pkg::PnW'(nq_nxt) * ceps_pkg::PnW'(ceps_pkg::Recip25);
      py_r   <= ceps_pkg::PyW'(yq_nxt) * ceps_pkg::PyW'(ceps_pkg::Recip25);
      ms_r   <= ceps_pkg::month_start(month);
      late_r <= (month > 4'd2);
      tf1_r  <= tf;
    end
  end

  // stage 2
  logic [8:0]                   qn;      // (year + 399) / 100
  logic [7:0]                   qy;      // year / 100
  logic [ceps_pkg::YqW-1:0]     rem25;
  logic                         leap;
  logic [ceps_pkg::DaysW-1:0]   yoff;
  logic [ceps_pkg::DaysW-1:0]   leaps_nxt;

  assign qn    = pn_r[ceps_pkg::PnW-1:ceps_pkg::RecipSh];
  assign qy    = py_r[ceps_pkg::PyW-1:ceps_pkg::RecipSh];
  assign rem25 = yr_r[ceps_pkg::YearW-1:2] - ceps_pkg::YqW'(qy) * ceps_pkg::YqW'(25);
  assign leap  = (yr_r[1:0] == 2'b00) && ((rem25 != '0) || (qy[1:0] == 2'b00));
  assign yoff  = ceps_pkg::DaysW'(yr_r) - ceps_pkg::DaysW'(ceps_pkg::EpochYear);
  assign leaps_nxt = ceps_pkg::DaysW'(nq_r) - ceps_pkg::DaysW'(qn)
                   + ceps_pkg::DaysW'(qn[8:2]) - ceps_pkg::DaysW'(ceps_pkg::LeapBase);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      front.year_days <= ceps_pkg::DaysW'(yoff * ceps_pkg::DaysW'(ceps_pkg::DaysPerYear));
      front.leaps     <= leaps_nxt;
      front.mstart    <= ms_r;
      front.leap_add  <= leap & late_r;
      front.tf        <= tf1_r;
    end
  end

endmodule

### rtl/core/ceps_day_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceps_day_sum
// Stage 3: total day count and seconds within the day.
// ----------------------------------------------------------------------------
module ceps_day_sum (
  input  logic              clk,
  input  logic              en,
  input  ceps_pkg::front_t  front,
  output ceps_pkg::days_t   dsum
);

  logic [ceps_pkg::DaysW-1:0] days_nxt;
  logic [ceps_pkg::TodW-1:0]  tod_nxt;

  // day zero lands on the last day of the month before
  assign days_nxt = front.year_days + front.leaps
                  + ceps_pkg::DaysW'(front.mstart)
                  + ceps_pkg::DaysW'(front.leap_add)
                  + ceps_pkg::DaysW'(front.tf.day) - ceps_pkg::DaysW'(1);

  assign tod_nxt = ceps_pkg::TodW'(front.tf.hour) * ceps_pkg::TodW'(ceps_pkg::SecsPerHour)
                 + ceps_pkg::TodW'(front.tf.minute) * ceps_pkg::TodW'(ceps_pkg::SecsPerMin)
                 + ceps_pkg::TodW'(front.tf.second);

  always_ff @(posedge clk) begin
    if (en) begin
      dsum.days <= days_nxt;
      dsum.tod  <= tod_nxt;
    end
  end

endmodule

### rtl/core/ceps_sec_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ceps_sec_sum
// Stages 4 and 5: days to seconds, then add the time of day.
// ----------------------------------------------------------------------------
module ceps_sec_sum (
  input  logic                       clk,
  input  logic                       en4,
  input  logic                       en5,
  input  ceps_pkg::days_t            dsum,
  output logic [ceps_pkg::OutW-1:0]  secs
);

  logic [ceps_pkg::OutW-1:0] dsec_r;
  logic [ceps_pkg::TodW-1:0] tod_r;
  logic [ceps_pkg::OutW-1:0] days_ext;

  // days may be negative before 1970; sign-extend, then wrap modulo 2^OutW
  assign days_ext = {{(ceps_pkg::OutW-ceps_pkg::DaysW){dsum.days[ceps_pkg::DaysW-1]}},
                     dsum.days};

  always_ff @(posedge clk) begin
    if (en4) begin
      dsec_r <= ceps_pkg::OutW'(days_ext * ceps_pkg::OutW'(ceps_pkg::SecsPerDay));
      tod_r  <= dsum.tod;
    end
    if (en5) begin
      secs <= dsec_r + ceps_pkg::OutW'(tod_r);
    end
  end

endmodule

### rtl/core/calendar_date_to_epoch_seconds.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the output is not stalled; five
// register stages, each with its own valid bit, so bubbles close up while
// the output is stalled.
// Reset: rst_n (synchronous, active low) clears all stage valid bits; the
// datapath registers are not reset.
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds
// Gregorian UTC date and time to seconds since 1970-01-01 00:00:00.
// ----------------------------------------------------------------------------
module calendar_date_to_epoch_seconds (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ceps_pkg::YearW-1:0]    in_year,
  input  logic [ceps_pkg::MonthW-1:0]   in_month,
  input  logic [ceps_pkg::DayW-1:0]     in_day,
  input  logic [ceps_pkg::HourW-1:0]    in_hour,
  input  logic [ceps_pkg::MinW-1:0]     in_minute,
  input  logic [ceps_pkg::SecW-1:0]     in_second,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ceps_pkg::OutW-1:0]     out_epoch_seconds
);

  // Stage map:
  //   1  (year+399)/4 and year/4 times the 1/25 reciprocal, month table
  //   2  divide results, leap test, (year-1970)*365, leap-year count
  //   3  day total, seconds within the day
  //   4  days * 86400
  //   5  final add into the output register

  logic [4:0]          v_r;
  logic [4:0]          v_nxt;
  logic [4:0]          hold;
  ceps_pkg::stage_en_t en;
  ceps_pkg::tod_fields_t tf_in;
  ceps_pkg::front_t    front;
  ceps_pkg::days_t     dsum;

  // A stage holds when it has a word and the stage after it holds; the last
  // stage holds when the output word is stalled.
  assign hold[4] = v_r[4] & out_stall;
  assign hold[3] = v_r[3] & hold[4];
  assign hold[2] = v_r[2] & hold[3];
  assign hold[1] = v_r[1] & hold[2];
  assign hold[0] = v_r[0] & hold[1];

  assign en.s1 = ~hold[0];
  assign en.s2 = ~hold[1];
  assign en.s3 = ~hold[2];
  assign en.s4 = ~hold[3];
  assign en.s5 = ~hold[4];

  always_comb begin
    v_nxt = v_r;
    if (en.s1) v_nxt[0] = in_valid;
    if (en.s2) v_nxt[1] = v_r[0];
    if (en.s3) v_nxt[2] = v_r[1];
    if (en.s4) v_nxt[3] = v_r[2];
    if (en.s5) v_nxt[4] = v_r[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = hold[0];
  assign out_valid = v_r[4];

  assign tf_in.day    = in_day;
  assign tf_in.hour   = in_hour;
  assign tf_in.minute = in_minute;
  assign tf_in.second = in_second;

  ceps_front u_front (
    .clk   (clk),
    .en    (en),
    .year  (in_year),
    .month (in_month),
    .tf    (tf_in),
    .front (front)
  );

  ceps_day_sum u_day_sum (
    .clk   (clk),
    .en    (en.s3),
    .front (front),
    .dsum  (dsum)
  );

  ceps_sec_sum u_sec_sum (
    .clk   (clk),
    .en4   (en.s4),
    .en5   (en.s5),
    .dsum  (dsum),
    .secs  (out_epoch_seconds)
  );

endmodule

### tb/sv/calendar_date_to_epoch_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_to_epoch_seconds_tb
// Drives broken-down dates into the epoch seconds pipeline and compares every
// output word against a hand-worked answer or a behavioral calculation of the
// day and second count. A directed table covers the calendar corners, then
// random dates follow with random idling on both sides of the pipe.
// ----------------------------------------------------------------------------
module calendar_date_to_epoch_seconds_tb;

  localparam int CycleLimit = 200000;
  localparam int PipeDepth  = 5;      // input word to out_valid
  localparam int RandWords  = 1100;

  typedef struct packed {
    logic [ceps_pkg::YearW-1:0]  year;
    logic [ceps_pkg::MonthW-1:0] month;
    logic [ceps_pkg::DayW-1:0]   day;
    logic [ceps_pkg::HourW-1:0]  hour;
    logic [ceps_pkg::MinW-1:0]   minute;
    logic [ceps_pkg::SecW-1:0]   second;
  } date_t;

  // one directed row; when known is set, secs is the hand-worked answer,
  // otherwise the answer comes from epoch_secs_of()
  typedef struct packed {
    logic [ceps_pkg::YearW-1:0]  year;
    logic [ceps_pkg::MonthW-1:0] month;
    logic [ceps_pkg::DayW-1:0]   day;
    logic [ceps_pkg::HourW-1:0]  hour;
    logic [ceps_pkg::MinW-1:0]   minute;
    logic [ceps_pkg::SecW-1:0]   second;
    logic                        known;
    logic [ceps_pkg::OutW-1:0]   secs;
  } date_row_t;

  localparam int NumRows = 23;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [ceps_pkg::YearW-1:0]  in_year;
  logic [ceps_pkg::MonthW-1:0] in_month;
  logic [ceps_pkg::DayW-1:0]   in_day;
  logic [ceps_pkg::HourW-1:0]  in_hour;
  logic [ceps_pkg::MinW-1:0]   in_minute;
  logic [ceps_pkg::SecW-1:0]   in_second;
  logic out_valid;
  logic out_stall;
  logic [ceps_pkg::OutW-1:0]   out_epoch_seconds;

  // epoch seconds still owed by the pipe, oldest first
  logic [ceps_pkg::OutW-1:0] pending_secs [$];
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;
  int unsigned src_idle_pct = 32;
  int unsigned sink_stall_pct = 32;

  // days before the first of each month, common year; slot 0 acts as January
  logic [8:0] cum_days [0:12] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  date_row_t date_rows [NumRows] = '{
    // epoch origin, one second past it, and a century-start midnight
    '{1970, 1, 1, 0, 0, 0, 1, 38'd0},
    '{1970, 1, 1, 0, 0, 1, 1, 38'd1},
    '{2000, 1, 1, 0, 0, 0, 1, 38'd946684800},
    // 32-bit signed rollover instant
    '{2038, 1, 19, 3, 14, 8, 1, 38'd2147483648},
    // last nominal second
    '{9999, 12, 31, 23, 59, 59, 1, 38'd253402300799},
    // day zero and the second before the epoch both wrap below zero
    '{1970, 1, 0, 0, 0, 0, 1, 38'd274877820544},
    '{1969, 12, 31, 23, 59, 59, 1, 38'd274877906943},
    // year field extremes: all zeros and all ones
    '{0, 1, 1, 0, 0, 0, 0, 38'd0},
    '{16383, 15, 31, 31, 63, 63, 0, 38'd0},
    // leap rules: 4, 100 and 400 year cases
    '{2000, 2, 29, 12, 0, 0, 0, 38'd0},
    '{2000, 3, 1, 0, 0, 0, 0, 38'd0},
    '{2100, 3, 1, 0, 0, 0, 0, 38'd0},
    '{1900, 3, 1, 0, 0, 0, 0, 38'd0},
    '{2400, 3, 1, 0, 0, 0, 0, 38'd0},
    '{2024, 12, 31, 0, 0, 0, 0, 38'd0},
    '{2023, 12, 31, 0, 0, 0, 0, 38'd0},
    // month zero behaves as January, past December saturates
    '{2020, 0, 15, 6, 30, 0, 0, 38'd0},
    '{2020, 13, 1, 0, 0, 0, 0, 38'd0},
    // out-of-range day, hour, minute, second just add time; then one nominal date
    '{1970, 2, 31, 0, 0, 0, 0, 38'd0},
    '{2020, 7, 31, 31, 0, 0, 0, 38'd0},
    '{2020, 7, 1, 0, 63, 0, 0, 38'd0},
    '{2020, 7, 1, 0, 0, 63, 0, 38'd0},
    '{5000, 6, 15, 8, 45, 30, 0, 38'd0}
  };

  calendar_date_to_epoch_seconds u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_year           (in_year),
    .in_month          (in_month),
    .in_day            (in_day),
    .in_hour           (in_hour),
    .in_minute         (in_minute),
    .in_second         (in_second),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_epoch_seconds (out_epoch_seconds)
  );

  always #5 clk = ~clk;

  // leap years in 1..n
  function automatic logic [63:0] leap_count(input logic [63:0] n);
    return n / 64'd4 - n / 64'd100 + n / 64'd400;
  endfunction

  // All arithmetic is done modulo 2^64 and truncated at the end, so years
  // before 1970 and day zero fold into the 38-bit wrap the same way.
  function automatic logic [ceps_pkg::OutW-1:0] epoch_secs_of(input date_t d);
    logic [63:0] yr;
    logic [63:0] mon;
    logic [63:0] days;
    logic [63:0] secs;
    logic        leap;
    yr   = 64'(d.year);
    mon  = (d.month > 4'd12) ? 64'd12 : 64'(d.month);
    leap = ((yr % 64'd4 == 0) && (yr % 64'd100 != 0)) || (yr % 64'd400 == 0);
    days = (yr - 64'(ceps_pkg::EpochYear)) * 64'(ceps_pkg::DaysPerYear);
    days = days + leap_count(yr + 64'(ceps_pkg::LeapShift))
         - leap_count(64'(ceps_pkg::EpochYear + ceps_pkg::LeapShift));
    days = days + 64'(cum_days[mon]);
    if (mon > 64'd2 && leap) begin
      days = days + 64'd1;
    end
    days = days + 64'(d.day) - 64'd1;
    secs = days * 64'(ceps_pkg::SecsPerDay)
         + 64'(d.hour) * 64'(ceps_pkg::SecsPerHour)
         + 64'(d.minute) * 64'(ceps_pkg::SecsPerMin)
         + 64'(d.second);
    return secs[ceps_pkg::OutW-1:0];
  endfunction

  // Called at a falling edge. Idles at random first, then holds the word
  // until the pipe takes it; returns at the next falling edge.
  task automatic offer_date(input date_t d, input logic [ceps_pkg::OutW-1:0] want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_year   <= d.year;
    in_month  <= d.month;
    in_day    <= d.day;
    in_hour   <= d.hour;
    in_minute <= d.minute;
    in_second <= d.second;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    pending_secs.push_back(want);
    @(negedge clk);
  endtask

  // sender goes quiet until every owed word has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (pending_secs.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Sink side: random stall, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Output checker: each accepted word is matched against the oldest owed one.
  always @(posedge clk) begin
    logic [ceps_pkg::OutW-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_secs.size() == 0) begin
        if (fault_count < 10) begin
          $display("%0t: output word %0d with nothing pending", $realtime,
                   out_epoch_seconds);
        end
        fault_count = fault_count + 1;
      end else begin
        want = pending_secs.pop_front();
        if (out_epoch_seconds !== want) begin
          if (fault_count < 10) begin
            $display("%0t: epoch_seconds exp %0d got %0d", $realtime, want,
                     out_epoch_seconds);
          end
          fault_count = fault_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("calendar_date_to_epoch_seconds_tb: errors");
    $finish;
  end

  initial begin
    date_t d;
    int unsigned pick;
    // every input known from time zero
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_year   = '0;
    in_month  = '0;
    in_day    = '0;
    in_hour   = '0;
    in_minute = '0;
    in_second = '0;
    out_stall = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    foreach (date_rows[i]) begin
      d = '{date_rows[i].year, date_rows[i].month, date_rows[i].day,
            date_rows[i].hour, date_rows[i].minute, date_rows[i].second};
      offer_date(d, date_rows[i].known ? date_rows[i].secs : epoch_secs_of(d));
    end
    hold_until_drained();

    // random dates; mostly nominal, the rest raw bits on every field
    for (int n = 0; n < RandWords; n++) begin
      // a long run with no idling on either side
      if (n == 450) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end else if (n == 700) begin
        src_idle_pct   = 32;
        sink_stall_pct = 32;
      end
      if (n == 300 || n == 850) begin
        hold_until_drained();
      end

      pick = $urandom_range(99);
      if (pick < 80) begin
        d.year   = ceps_pkg::YearW'($urandom_range(9999, 1970));
        // centuries exercise the 100 and 400 year rules
        if ($urandom_range(3) == 0) begin
          d.year = 14'(100 * $urandom_range(99, 20));
        end
        d.month  = ceps_pkg::MonthW'($urandom_range(12, 1));
        d.day    = ceps_pkg::DayW'($urandom_range(31, 1));
        d.hour   = ceps_pkg::HourW'($urandom_range(23, 0));
        d.minute = ceps_pkg::MinW'($urandom_range(59, 0));
        d.second = ceps_pkg::SecW'($urandom_range(59, 0));
      end else begin
        d.year   = ceps_pkg::YearW'($urandom);
        d.month  = ceps_pkg::MonthW'($urandom);
        d.day    = ceps_pkg::DayW'($urandom);
        d.hour   = ceps_pkg::HourW'($urandom);
        d.minute = ceps_pkg::MinW'($urandom);
        d.second = ceps_pkg::SecW'($urandom);
      end
      offer_date(d, epoch_secs_of(d));
    end

    hold_until_drained();
    // catch any stray word trailing the last expected one
    repeat (2 * PipeDepth) @(posedge clk);

    if (fault_count == 0) begin
      $display("calendar_date_to_epoch_seconds_tb: clean");
    end else begin
      $display("calendar_date_to_epoch_seconds_tb: errors");
    end
    $finish;
  end

endmodule
